[hw/rtl/greedy_radius_point_thinning_assert.svh]
// Assertion macros for the point thinning block
`ifndef GREEDY_RADIUS_POINT_THINNING_ASSERT_SVH
`define GREEDY_RADIUS_POINT_THINNING_ASSERT_SVH

`ifndef SYNTHESIS
`define GRPT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define GRPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GRPT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define GRPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[hw/rtl/grpt_pkg.sv]
// Shared constants, types and state codes of the point thinning block
`default_nettype none
package grpt_pkg;

   localparam int MAX_KEPT    = 64;
   localparam int COORD_BITS  = 16;
   localparam int RADIUS_BITS = 16;

   localparam int ADDR_BITS = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_BITS  = $clog2(MAX_KEPT + 1);
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int SUM_BITS  = SQ_BITS + 1;
   localparam int R2_BITS   = 2 * RADIUS_BITS;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(128);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_coord;
      logic signed [COORD_BITS-1:0] y_coord;
      logic                         last_point;
   } grpt_req_type;

   typedef struct packed {
      logic keep;
      logic store_overflow;
      logic set_done;
   } grpt_rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } grpt_point_type;

   typedef struct packed {
      logic busy;
      logic near_hit;
   } grpt_dist_status_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_DECIDE = 4'b1000
   } grpt_state_type;

endpackage
`default_nettype wire

[hw/rtl/grpt_kept_mem.sv]
// Store of kept points: one write port, one registered read port
`default_nettype none
module grpt_kept_mem (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [grpt_pkg::ADDR_BITS-1:0]     wr_addr,
   input  wire grpt_pkg::grpt_point_type           wr_data,
   input  wire logic [grpt_pkg::ADDR_BITS-1:0]     rd_addr,
   output      grpt_pkg::grpt_point_type           rd_data
);

   grpt_pkg::grpt_point_type mem_ff [grpt_pkg::MAX_KEPT];
   grpt_pkg::grpt_point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/grpt_dist_unit.sv]
// Pipelined squared-distance check of the current point against one stored point a cycle
`default_nettype none
module grpt_dist_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              issue_valid,
   input  wire grpt_pkg::grpt_point_type          cur_point,
   input  wire grpt_pkg::grpt_point_type          kept_point,
   input  wire logic [grpt_pkg::R2_BITS-1:0]      radius_sq,
   output      grpt_pkg::grpt_dist_status_type    status
);

   logic                                 rd_v_ff, v1_ff, v2_ff, v3_ff;
   logic [grpt_pkg::COORD_BITS-1:0]      abs_x_ff, abs_y_ff, abs_x_in, abs_y_in;
   logic [grpt_pkg::SQ_BITS-1:0]         sq_x_ff, sq_y_ff, sq_x_in, sq_y_in;
   logic                                 near_ff, near_in;
   logic [grpt_pkg::DIFF_BITS-1:0]       diff_x, diff_y, mag_x, mag_y;
   logic [grpt_pkg::SUM_BITS-1:0]        sum;

   always_comb begin
      diff_x = {cur_point.x[grpt_pkg::COORD_BITS-1], cur_point.x}
             - {kept_point.x[grpt_pkg::COORD_BITS-1], kept_point.x};
      diff_y = {cur_point.y[grpt_pkg::COORD_BITS-1], cur_point.y}
             - {kept_point.y[grpt_pkg::COORD_BITS-1], kept_point.y};
      // magnitude of a sign-extended difference always fits the coordinate width
      mag_x = diff_x[grpt_pkg::DIFF_BITS-1] ? (~diff_x + grpt_pkg::DIFF_BITS'(1)) : diff_x;
      mag_y = diff_y[grpt_pkg::DIFF_BITS-1] ? (~diff_y + grpt_pkg::DIFF_BITS'(1)) : diff_y;
      abs_x_in = mag_x[grpt_pkg::COORD_BITS-1:0];
      abs_y_in = mag_y[grpt_pkg::COORD_BITS-1:0];

      sq_x_in = grpt_pkg::SQ_BITS'(abs_x_ff) * grpt_pkg::SQ_BITS'(abs_x_ff);
      sq_y_in = grpt_pkg::SQ_BITS'(abs_y_ff) * grpt_pkg::SQ_BITS'(abs_y_ff);

      sum     = grpt_pkg::SUM_BITS'(sq_x_ff) + grpt_pkg::SUM_BITS'(sq_y_ff);
      near_in = !(sum > grpt_pkg::SUM_BITS'(radius_sq));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
      end else begin
         rd_v_ff <= issue_valid;
         v1_ff   <= rd_v_ff;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
      end
      abs_x_ff <= abs_x_in;
      abs_y_ff <= abs_y_in;
      sq_x_ff  <= sq_x_in;
      sq_y_ff  <= sq_y_in;
      near_ff  <= near_in;
   end

   assign status.busy     = rd_v_ff | v1_ff | v2_ff | v3_ff;
   assign status.near_hit = v3_ff & near_ff;

endmodule
`default_nettype wire

[hw/rtl/greedy_radius_point_thinning.sv]
// Greedy radius thinning: each point is checked against the kept store, one entry a cycle.
// An accepted point passes through the scan, drain and decide states before its result is registered.
// A new request is accepted only in the idle state, once the previous result has been loaded.
// Reset (synchronous): store empties, radius returns to 128, result register is emptied.
// No clearing pass: entries at or above the kept count are never read.
`default_nettype none
`include "greedy_radius_point_thinning_assert.svh"
module greedy_radius_point_thinning (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire grpt_pkg::grpt_req_type              req_data,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      grpt_pkg::grpt_rsp_type              rsp_data,
   input  wire logic                                csr_wr_en,
   input  wire logic [grpt_pkg::RADIUS_BITS-1:0]    csr_wr_data
);

   grpt_pkg::grpt_state_type               state_ff, state_in;
   logic [grpt_pkg::RADIUS_BITS-1:0]       radius_ff;
   logic [grpt_pkg::R2_BITS-1:0]           r2_ff;
   logic [grpt_pkg::CNT_BITS-1:0]          count_ff, count_in;
   logic [grpt_pkg::CNT_BITS-1:0]          issue_ff, issue_in;
   logic                                   hit_ff, hit_in;
   grpt_pkg::grpt_req_type                 req_ff, req_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   grpt_pkg::grpt_rsp_type                 rsp_data_ff, rsp_data_in;

   logic                                   req_accept;
   logic                                   issue_valid;
   logic                                   load_rsp;
   logic                                   store_full;
   logic                                   wr_en;
   grpt_pkg::grpt_point_type               cur_point;
   grpt_pkg::grpt_point_type               kept_point;
   grpt_pkg::grpt_dist_status_type         dist_status;

   assign req_stall  = (state_ff != grpt_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign store_full = (count_ff == grpt_pkg::CNT_BITS'(grpt_pkg::MAX_KEPT));
   assign cur_point.x = req_ff.x_coord;
   assign cur_point.y = req_ff.y_coord;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      hit_in       = hit_ff | dist_status.near_hit;
      req_in       = req_ff;
      issue_valid  = 1'b0;
      load_rsp     = 1'b0;
      wr_en        = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         grpt_pkg::ST_IDLE: begin
            if (req_accept) begin
               req_in   = req_data;
               issue_in = '0;
               hit_in   = 1'b0;
               state_in = grpt_pkg::ST_SCAN;
            end
         end
         grpt_pkg::ST_SCAN: begin
            if (issue_ff < count_ff) begin
               issue_valid = 1'b1;
               issue_in    = issue_ff + grpt_pkg::CNT_BITS'(1);
            end else begin
               state_in = grpt_pkg::ST_DRAIN;
            end
         end
         grpt_pkg::ST_DRAIN: begin
            if (!dist_status.busy) begin
               state_in = grpt_pkg::ST_DECIDE;
            end
         end
         grpt_pkg::ST_DECIDE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp                   = 1'b1;
               rsp_valid_in               = 1'b1;
               rsp_data_in.keep           = !hit_ff;
               rsp_data_in.store_overflow = !hit_ff && store_full;
               rsp_data_in.set_done       = req_ff.last_point;
               if (!hit_ff && !store_full) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + grpt_pkg::CNT_BITS'(1);
               end
               if (req_ff.last_point) begin
                  count_in = '0;
               end
               state_in = grpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = grpt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grpt_pkg::ST_IDLE;
         radius_ff    <= grpt_pkg::RADIUS_RESET;
         r2_ff        <= grpt_pkg::R2_BITS'(grpt_pkg::RADIUS_RESET)
                       * grpt_pkg::R2_BITS'(grpt_pkg::RADIUS_RESET);
         count_ff     <= '0;
         issue_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
         r2_ff        <= grpt_pkg::R2_BITS'(radius_ff) * grpt_pkg::R2_BITS'(radius_ff);
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   grpt_kept_mem u_kept_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[grpt_pkg::ADDR_BITS-1:0]),
      .wr_data (cur_point),
      .rd_addr (issue_ff[grpt_pkg::ADDR_BITS-1:0]),
      .rd_data (kept_point)
   );

   grpt_dist_unit u_dist_unit (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .cur_point   (cur_point),
      .kept_point  (kept_point),
      .radius_sq   (r2_ff),
      .status      (dist_status)
   );

   `GRPT_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_accept, state_ff == grpt_pkg::ST_SCAN, "request accepted but scan not started")
   `GRPT_ASSERT_NEXT(a_last_clears_store, clock, reset, load_rsp && req_ff.last_point, count_ff == '0, "store not cleared after last point")
   `GRPT_ASSERT_IMPLIES(a_overflow_when_full, clock, reset, load_rsp && rsp_data_in.store_overflow, store_full && !hit_ff, "overflow flagged with room in store")

endmodule
`default_nettype wire

[verif/grpt_thinning_checker.sv]
// Checker for the point thinning block: predicts the keep, overflow and done flags and compares responses
module grpt_thinning_checker
   import grpt_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire grpt_req_type           req_data,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire grpt_rsp_type           rsp_data,
   input  wire logic                   csr_wr_en,
   input  wire logic [RADIUS_BITS-1:0] csr_wr_data,
   output int                          error_count,
   output int                          flags_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [COORD_BITS-1:0] store_x [MAX_KEPT];
   logic signed [COORD_BITS-1:0] store_y [MAX_KEPT];
   int                           n_stored;
   logic [RADIUS_BITS-1:0]       radius_copy;
   grpt_rsp_type                 flags_due_q [$];

   // Decide one point against the kept store and update the store.
   function automatic grpt_rsp_type thin_point(grpt_req_type pt);
      grpt_rsp_type res;
      longint       dx;
      longint       dy;
      longint       r_sq;
      res.keep           = 1'b1;
      res.store_overflow = 1'b0;
      res.set_done       = pt.last_point;
      r_sq = longint'(radius_copy) * longint'(radius_copy);
      for (int k = 0; k < n_stored; k++) begin
         dx = longint'(pt.x_coord) - longint'(store_x[k]);
         dy = longint'(pt.y_coord) - longint'(store_y[k]);
         if (dx * dx + dy * dy <= r_sq) begin
            res.keep = 1'b0;
            break;
         end
      end
      if (res.keep) begin
         if (n_stored < MAX_KEPT) begin
            store_x[n_stored] = pt.x_coord;
            store_y[n_stored] = pt.y_coord;
            n_stored++;
         end else begin
            res.store_overflow = 1'b1;
         end
      end
      if (pt.last_point) begin
         n_stored = 0;
      end
      return res;
   endfunction

   task automatic check_flags(grpt_rsp_type got);
      grpt_rsp_type want;
      if (flags_due_q.size() == 0) begin
         $display("%0t ns: response with none due: got %b", $time, got);
         error_count++;
      end else begin
         want = flags_due_q.pop_front();
         if (got.keep !== want.keep) begin
            $display("%0t ns: keep expected %b, got %b", $time, want.keep, got.keep);
            error_count++;
         end
         if (got.store_overflow !== want.store_overflow) begin
            $display("%0t ns: store_overflow expected %b, got %b", $time,
                     want.store_overflow, got.store_overflow);
            error_count++;
         end
         if (got.set_done !== want.set_done) begin
            $display("%0t ns: set_done expected %b, got %b", $time,
                     want.set_done, got.set_done);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         flags_due_q.delete();
         n_stored    = 0;
         radius_copy = RADIUS_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_flags(rsp_data);
         end
         if (req_valid && !req_stall) begin
            flags_due_q.push_back(thin_point(req_data));
         end
         if (csr_wr_en) begin
            radius_copy = csr_wr_data;
         end
      end
      flags_pending = flags_due_q.size();
   end

endmodule

[verif/tb_greedy_radius_point_thinning.sv]
// Testbench top for the point thinning block: clock, reset, point stimulus and verdict
module tb_greedy_radius_point_thinning;
   timeunit 1ns;
   timeprecision 1ps;
   import grpt_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = MAX_KEPT + 16;
   localparam int IDLE_PCT      = 28;
   localparam int N_PHASES      = 8;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   grpt_req_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   grpt_rsp_type           rsp_data;
   logic                   csr_wr_en;
   logic [RADIUS_BITS-1:0] csr_wr_data;
   int                     error_count;
   int                     flags_pending;
   int                     cycle_count;
   bit                     no_idle;
   logic [RADIUS_BITS-1:0] radius_now;

   greedy_radius_point_thinning i_dut (.*);

   grpt_thinning_checker i_checker (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("tb_greedy_radius_point_thinning: done, errors");
      $finish;
   end

   // Response side: stall at random except during the quiet stretch.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   task automatic send_point(input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y,
                             input logic last);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_data  <= grpt_req_type'($urandom);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{x_coord: x, y_coord: y, last_point: last};
      do @(posedge clock); while (req_stall);
   endtask

   // Hold the sender until every request has its response.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (flags_pending != 0) @(negedge clock);
   endtask

   task automatic write_radius(input logic [RADIUS_BITS-1:0] r);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= r;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      radius_now = r;
   endtask

   // Sets of points around a centre, with spread points and repeats mixed in.
   // A long set fills the store with spread points and then goes on past it.
   task automatic random_sets(input int n_points, input bit long_first);
      int                           sent;
      int                           len;
      int                           span;
      int                           cx;
      int                           cy;
      int                           roll;
      bit                           long_set;
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
      sent     = 0;
      long_set = long_first;
      px       = '0;
      py       = '0;
      while (sent < n_points || long_set) begin
         if (long_set) begin
            len = MAX_KEPT + $urandom_range(3, 8);
         end else if ($urandom_range(0, 9) < 2) begin
            len = $urandom_range(1, 2);
         end else begin
            len = $urandom_range(3, 14);
         end
         cx   = $urandom_range(0, 65535);
         cy   = $urandom_range(0, 65535);
         span = 2 * radius_now + 4;
         for (int i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            if ((long_set && i <= MAX_KEPT) || roll < 30) begin
               px = COORD_BITS'($urandom);
               py = COORD_BITS'($urandom);
            end else if (roll < 42 && i > 0) begin
               // repeat the previous point
            end else begin
               px = COORD_BITS'(cx + int'($urandom_range(0, 2 * span)) - span);
               py = COORD_BITS'(cy + int'($urandom_range(0, 2 * span)) - span);
            end
            send_point(px, py, i == len - 1);
         end
         sent += len;
         long_set = 1'b0;
      end
   endtask

   initial begin
      logic [RADIUS_BITS-1:0] phase_radius [N_PHASES];
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      no_idle     = 1'b0;
      radius_now  = RADIUS_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset radius 128: duplicates, the exact boundary, the corners, a lone point.
      send_point(0, 0, 1'b0);
      send_point(0, 0, 1'b0);
      send_point(128, 0, 1'b0);
      send_point(0, -128, 1'b0);
      send_point(129, 0, 1'b0);
      send_point(-32768, -32768, 1'b0);
      send_point(32767, 32767, 1'b0);
      send_point(-32768, 32767, 1'b0);
      send_point(32767, -32768, 1'b1);
      send_point(0, 0, 1'b1);

      // Zero radius: only exact duplicates drop out.
      write_radius('0);
      send_point(5, 5, 1'b0);
      send_point(5, 5, 1'b0);
      send_point(5, 6, 1'b0);
      send_point(-1, -1, 1'b1);

      // Largest radius: a full-width step lands exactly on the boundary.
      write_radius('1);
      send_point(-32768, -32768, 1'b0);
      send_point(32767, 32767, 1'b0);
      send_point(0, 0, 1'b0);
      send_point(-32768, 32767, 1'b1);

      phase_radius[0] = RADIUS_RESET;
      phase_radius[1] = '0;
      phase_radius[2] = '1;
      phase_radius[3] = RADIUS_BITS'(1);
      phase_radius[4] = RADIUS_BITS'(256);
      phase_radius[5] = RADIUS_BITS'($urandom_range(0, 4095));
      phase_radius[6] = RADIUS_BITS'(2048);
      phase_radius[7] = RADIUS_BITS'($urandom);
      for (int p = 0; p < N_PHASES; p++) begin
         write_radius(phase_radius[p]);
         no_idle = (p == 2);
         random_sets(40, p == 1 || p == 4);
         no_idle = 1'b0;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && flags_pending == 0) begin
         $display("tb_greedy_radius_point_thinning: done, clean");
      end else begin
         $display("tb_greedy_radius_point_thinning: done, errors");
      end
      $finish;
   end

endmodule
